>>> design/fp16as_pkg.sv
package fp16as_pkg;

    localparam logic [15:0] QNAN_BITS = 16'h7E00;
    localparam logic [14:0] INF_BITS  = 15'h7C00;

    typedef struct packed {
        logic        mode;
        logic [15:0] first_operand;
        logic [15:0] second_operand;
        logic        last_in;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] result_value;
        logic        overflow;
        logic        last_out;
    } out_beat_t;

    // Magnitude of finite value in units of 2^-24 (max 0x7FF << 29 -> 40 bits).
    function automatic logic [40:0] unit_mag(input logic [14:0] h);
        logic [4:0]  e;
        logic [40:0] m;
        begin
            e = h[14:10];
            m = {31'd0, h[9:0]};
            if (e == 5'd0)
                unit_mag = m;
            else
                unit_mag = (m | 41'd1024) << (e - 5'd1);
        end
    endfunction

endpackage

>>> design/fp16as_round.sv
module fp16as_round (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic [41:0] mag,
    input  logic        sign,
    input  logic        special,
    input  logic [15:0] special_res,
    input  logic        last,
    output logic        out_vld,
    output fp16as_pkg::out_beat_t out_beat
);
    import fp16as_pkg::*;

    // stage A: leading-one position
    logic        a_vld_reg;
    logic [41:0] a_mag_reg;
    logic        a_sign_reg, a_spec_reg, a_last_reg;
    logic [15:0] a_sres_reg;
    logic [5:0]  a_top_reg;
    logic [5:0]  top_next;

    always_comb
    begin
        top_next = 6'd0;
        for (int i = 0; i < 42; i++)
        begin
            if (mag[i])
                top_next = 6'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg  <= mag;
        a_sign_reg <= sign;
        a_spec_reg <= special;
        a_sres_reg <= special_res;
        a_last_reg <= last;
        a_top_reg  <= top_next;
    end

    // stage B: shift and round
    logic        b_vld_reg;
    logic [15:0] b_res_reg;
    logic        b_last_reg;
    logic [15:0] res_next;
    logic [5:0]  shift;
    logic [41:0] keep, rem, halfway, lowmask;
    logic [11:0] k;
    logic [5:0]  e;

    always_comb
    begin
        shift    = a_top_reg - 6'd10;
        e        = shift + 6'd1;
        keep     = a_mag_reg >> shift;
        lowmask  = (42'd1 << shift) - 42'd1;
        rem      = a_mag_reg & lowmask;
        halfway  = (shift == 6'd0) ? 42'd0 : (42'd1 << (shift - 6'd1));
        k        = {1'b0, keep[10:0]};
        if (shift != 6'd0 && (rem > halfway || (rem == halfway && keep[0])))
            k = k + 12'd1;
        if (k == 12'd2048)
        begin
            k = 12'd1024;
            e = e + 6'd1;
        end
        if (a_spec_reg)
            res_next = a_sres_reg;
        else if (a_mag_reg == 42'd0)
            res_next = {a_sign_reg, 15'd0};
        else if (a_mag_reg < 42'd1024)
            res_next = {a_sign_reg, 5'd0, a_mag_reg[9:0]};
        else if (e >= 6'd31)
            res_next = {a_sign_reg, INF_BITS};
        else
            res_next = {a_sign_reg, e[4:0], k[9:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_res_reg  <= res_next;
        b_last_reg <= a_last_reg;
    end

    assign out_vld               = b_vld_reg;
    assign out_beat.result_value = b_res_reg;
    assign out_beat.overflow     = (b_res_reg[14:0] == INF_BITS);
    assign out_beat.last_out     = b_last_reg;
endmodule

>>> design/fp16_vector_add_sub_core.sv
// channel | signals                     | rule
// in      | start, busy, in_beat        | beat taken when start && !busy
// out     | strobe, out_beat            | beat valid one cycle, no backpressure
// Registered stages: align, add, leading-one, round.
// One beat per cycle; busy is always low.
// Async active-low reset clears valid bits only.
module fp16_vector_add_sub_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  fp16as_pkg::in_beat_t  in_beat,
    output logic                  strobe,
    output fp16as_pkg::out_beat_t out_beat
);
    import fp16as_pkg::*;

    assign busy = 1'b0;

    // stage 1: decode and align
    logic        s1_vld_reg;
    logic [40:0] s1_ma_reg, s1_mb_reg;
    logic        s1_sa_reg, s1_sb_reg, s1_spec_reg, s1_last_reg;
    logic [15:0] s1_sres_reg;
    logic        sa, sb, as, bs, an, bn, spec;
    logic [15:0] sres;
    logic [15:0] a, b;

    always_comb
    begin
        a    = in_beat.first_operand;
        b    = in_beat.second_operand;
        sa   = a[15];
        sb   = b[15] ^ in_beat.mode;
        as   = &a[14:10];
        bs   = &b[14:10];
        an   = as && (a[9:0] != 10'd0);
        bn   = bs && (b[9:0] != 10'd0);
        spec = as || bs;
        if (an || bn)
            sres = QNAN_BITS;
        else if (as && bs)
            sres = (sa == sb) ? {sa, INF_BITS} : QNAN_BITS;
        else if (as)
            sres = {sa, INF_BITS};
        else
            sres = {sb, INF_BITS};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_ma_reg   <= unit_mag(a[14:0]);
        s1_mb_reg   <= unit_mag(b[14:0]);
        s1_sa_reg   <= sa;
        s1_sb_reg   <= sb;
        s1_spec_reg <= spec;
        s1_sres_reg <= sres;
        s1_last_reg <= in_beat.last_in;
    end

    // stage 2: signed-magnitude add
    logic        s2_vld_reg;
    logic [41:0] s2_mag_reg;
    logic        s2_sign_reg, s2_spec_reg, s2_last_reg;
    logic [15:0] s2_sres_reg;
    logic [41:0] mag_next;
    logic        sign_next;

    always_comb
    begin
        if (s1_sa_reg == s1_sb_reg)
        begin
            mag_next  = {1'b0, s1_ma_reg} + {1'b0, s1_mb_reg};
            sign_next = s1_sa_reg;
        end
        else if (s1_ma_reg >= s1_mb_reg)
        begin
            mag_next  = {1'b0, s1_ma_reg - s1_mb_reg};
            sign_next = (s1_ma_reg == s1_mb_reg) ? 1'b0 : s1_sa_reg;
        end
        else
        begin
            mag_next  = {1'b0, s1_mb_reg - s1_ma_reg};
            sign_next = s1_sb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_mag_reg  <= mag_next;
        s2_sign_reg <= sign_next;
        s2_spec_reg <= s1_spec_reg;
        s2_sres_reg <= s1_sres_reg;
        s2_last_reg <= s1_last_reg;
    end

    fp16as_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (s2_vld_reg),
        .mag         (s2_mag_reg),
        .sign        (s2_sign_reg),
        .special     (s2_spec_reg),
        .special_res (s2_sres_reg),
        .last        (s2_last_reg),
        .out_vld     (strobe),
        .out_beat    (out_beat)
    );

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 strobe)
        else $error("strobe latency broken");
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && out_beat.overflow |-> out_beat.result_value[14:10] == 5'h1F)
        else $error("overflow without infinity");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 (out_beat.last_out == $past(in_beat.last_in, 4)))
        else $error("last mark lost");
`endif
endmodule
